@@ rtl/itc_pkg.sv @@
// Shared types and constants of the interrupt and timer controller.
`timescale 1ns / 1ps
package itc_pkg;

  localparam int unsigned DATA_W             = 32;
  localparam int unsigned STATUS_DELAY_DEPTH = 4;

  // request kinds
  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_START = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  // register map
  typedef enum logic [2:0] {
    REG_VECTOR   = 3'd0,
    REG_CAUSE    = 3'd1,
    REG_MASK     = 3'd2,
    REG_STATUS   = 3'd3,
    REG_EPC      = 3'd4,
    REG_COUNTER  = 3'd5,
    REG_COMPARE  = 3'd6,
    REG_COMPARE2 = 3'd7
  } reg_idx_t;

  localparam logic [DATA_W-1:0] CAUSE_READ_SET   = 32'h0000_00C0;
  localparam logic [DATA_W-1:0] CAUSE_KEEP_CMP   = 32'h0000_FFEF;
  localparam logic [DATA_W-1:0] CAUSE_KEEP_CMP2  = 32'h0000_FFDF;
  localparam logic [DATA_W-1:0] CAUSE_KEEP_TICK  = 32'h0000_FFF0;
  localparam logic [DATA_W-1:0] EPC_STEP         = 32'd4;
  localparam int unsigned       CMP2_BITS        = 24;
  localparam int unsigned       CNT_BIT_LO       = 16;
  localparam int unsigned       CNT_BIT_HI       = 18;
  localparam int unsigned       CAUSE_CMP_BIT    = 4;
  localparam int unsigned       CAUSE_CMP2_BIT   = 5;

endpackage

@@ rtl/itc_in_if.sv @@
// Request channel of the interrupt and timer controller.
`timescale 1ns / 1ps
interface itc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [2:0]  reg_index;
  logic [31:0] write_data;
  logic [31:0] fetch_pc;
  logic        in_delay_slot;

  modport source (output valid, output req_type, output reg_index, output write_data,
                  output fetch_pc, output in_delay_slot, input ready);
  modport sink   (input valid, input req_type, input reg_index, input write_data,
                  input fetch_pc, input in_delay_slot, output ready);
endinterface

@@ rtl/itc_out_if.sv @@
// Result channel of the interrupt and timer controller.
`timescale 1ns / 1ps
interface itc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        take_irq;
  logic [31:0] irq_target;

  modport source (output valid, output read_data, output take_irq, output irq_target,
                  input ready);
  modport sink   (input valid, input read_data, input take_irq, input irq_target,
                  output ready);
endinterface

@@ rtl/interrupt_timer_controller_unit.sv @@
// Interrupt controller with a timer counter, advanced by tick requests, and compare registers.
// An accepted request's result appears in the output register in the next cycle.
// Throughput: one request per cycle while results are taken; the output register frees as its result is taken,
// so a new request is accepted in the same cycle the previous result leaves.
// Reset (rst, synchronous): the control and timer registers, the status delay line and the output valid clear.
`timescale 1ns / 1ps
module interrupt_timer_controller_unit #(
  parameter int unsigned STATUS_DELAY_DEPTH = itc_pkg::STATUS_DELAY_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  itc_in_if.sink    req_ch,
  itc_out_if.source rsp_ch
);

  localparam int unsigned W    = itc_pkg::DATA_W;
  localparam int unsigned LAST = STATUS_DELAY_DEPTH - 1;

  logic [W-1:0] vec, vec_next;
  logic [W-1:0] cause, cause_next;
  logic [W-1:0] mask, mask_next;
  logic [W-1:0] status, status_next;
  logic [W-1:0] status_delay [STATUS_DELAY_DEPTH];
  logic [W-1:0] status_delay_next [STATUS_DELAY_DEPTH];
  logic [W-1:0] saved_pc, saved_pc_next;
  logic [W-1:0] tick_count, tick_count_next;
  logic [W-1:0] compare_a, compare_a_next;
  logic [W-1:0] compare_b, compare_b_next;

  logic         out_valid;
  logic [W-1:0] read_data, read_data_next;
  logic         take_irq, take_irq_next;
  logic [W-1:0] irq_target, irq_target_next;

  logic            accept;
  itc_pkg::req_t   req;
  itc_pkg::reg_idx_t idx;

  assign req_ch.ready = !out_valid || rsp_ch.ready;
  assign accept       = req_ch.valid && req_ch.ready;
  assign req          = itc_pkg::req_t'(req_ch.req_type);
  assign idx          = itc_pkg::reg_idx_t'(req_ch.reg_index);

  always_comb begin
    vec_next    = vec;
    cause_next  = cause;
    mask_next   = mask;
    status_next = status;
    for (int i = 0; i < STATUS_DELAY_DEPTH; i++) begin
      status_delay_next[i] = status_delay[i];
    end
    saved_pc_next   = saved_pc;
    tick_count_next = tick_count;
    compare_a_next  = compare_a;
    compare_b_next  = compare_b;
    read_data_next  = '0;
    take_irq_next   = 1'b0;
    irq_target_next = '0;

    unique case (req)
      itc_pkg::REQ_READ: begin
        unique case (idx)
          itc_pkg::REG_VECTOR:   read_data_next = vec;
          itc_pkg::REG_CAUSE:    read_data_next = cause | itc_pkg::CAUSE_READ_SET;
          itc_pkg::REG_MASK:     read_data_next = mask;
          itc_pkg::REG_STATUS:   read_data_next = status;
          itc_pkg::REG_EPC:      read_data_next = saved_pc;
          itc_pkg::REG_COUNTER:  read_data_next = tick_count;
          itc_pkg::REG_COMPARE:  read_data_next = compare_a;
          itc_pkg::REG_COMPARE2: read_data_next = compare_b;
          default:               read_data_next = '0;
        endcase
      end
      itc_pkg::REQ_WRITE: begin
        unique case (idx)
          itc_pkg::REG_VECTOR:  vec_next   = req_ch.write_data;
          itc_pkg::REG_CAUSE:   cause_next = req_ch.write_data;
          itc_pkg::REG_MASK:    mask_next  = req_ch.write_data;
          itc_pkg::REG_STATUS: begin
            // zero clears status and the whole line, anything else loads the tail
            if (req_ch.write_data == '0) begin
              status_next = '0;
              for (int i = 0; i < STATUS_DELAY_DEPTH; i++) begin
                status_delay_next[i] = '0;
              end
            end else begin
              status_delay_next[LAST] = req_ch.write_data;
            end
          end
          itc_pkg::REG_EPC:     saved_pc_next   = req_ch.write_data;
          itc_pkg::REG_COUNTER: tick_count_next = req_ch.write_data;
          itc_pkg::REG_COMPARE: begin
            compare_a_next = req_ch.write_data;
            cause_next     = cause & itc_pkg::CAUSE_KEEP_CMP;
          end
          itc_pkg::REG_COMPARE2: begin
            compare_b_next = req_ch.write_data;
            cause_next     = cause & itc_pkg::CAUSE_KEEP_CMP2;
          end
          default: ;
        endcase
      end
      itc_pkg::REQ_START: begin
        if (status != '0 && (cause & mask) != '0 && !req_ch.in_delay_slot) begin
          saved_pc_next = req_ch.fetch_pc + itc_pkg::EPC_STEP;
          status_next   = '0;
          for (int i = 0; i < STATUS_DELAY_DEPTH; i++) begin
            status_delay_next[i] = '0;
          end
          take_irq_next   = 1'b1;
          irq_target_next = vec;
        end else begin
          // advance the line towards stage 0, tail holds
          status_next = status_delay[0];
          for (int i = 0; i < STATUS_DELAY_DEPTH - 1; i++) begin
            status_delay_next[i] = status_delay[i+1];
          end
        end
      end
      itc_pkg::REQ_TICK: begin
        tick_count_next = tick_count + W'(1);
        cause_next      = cause & itc_pkg::CAUSE_KEEP_TICK;
        if (compare_b[itc_pkg::CMP2_BITS-1:0] == tick_count_next[itc_pkg::CMP2_BITS-1:0]) begin
          cause_next[itc_pkg::CAUSE_CMP2_BIT] = 1'b1;
        end
        if (compare_a == tick_count_next) begin
          cause_next[itc_pkg::CAUSE_CMP_BIT] = 1'b1;
        end
        cause_next[3] = !tick_count_next[itc_pkg::CNT_BIT_LO];
        cause_next[2] = tick_count_next[itc_pkg::CNT_BIT_LO];
        cause_next[1] = !tick_count_next[itc_pkg::CNT_BIT_HI];
        cause_next[0] = tick_count_next[itc_pkg::CNT_BIT_HI];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vec    <= '0;
      cause  <= '0;
      mask   <= '0;
      status <= '0;
      for (int i = 0; i < STATUS_DELAY_DEPTH; i++) begin
        status_delay[i] <= '0;
      end
      saved_pc   <= '0;
      tick_count <= '0;
      compare_a  <= '0;
      compare_b  <= '0;
    end else if (accept) begin
      vec    <= vec_next;
      cause  <= cause_next;
      mask   <= mask_next;
      status <= status_next;
      for (int i = 0; i < STATUS_DELAY_DEPTH; i++) begin
        status_delay[i] <= status_delay_next[i];
      end
      saved_pc   <= saved_pc_next;
      tick_count <= tick_count_next;
      compare_a  <= compare_a_next;
      compare_b  <= compare_b_next;
    end
  end

  // result register: load on accept, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data  <= read_data_next;
      take_irq   <= take_irq_next;
      irq_target <= irq_target_next;
    end
  end

  assign rsp_ch.valid      = out_valid;
  assign rsp_ch.read_data  = read_data;
  assign rsp_ch.take_irq   = take_irq;
  assign rsp_ch.irq_target = irq_target;

endmodule

@@ test/itc_tb_pkg.sv @@
// Request and result types, and the scoreboard that predicts and checks controller results.
`timescale 1ns / 1ps
package itc_tb_pkg;
  import itc_pkg::*;

  typedef struct packed {
    req_t        kind;
    reg_idx_t    idx;
    logic [31:0] wdata;
    logic [31:0] pc;
    logic        slot;
  } request_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        take;
    logic [31:0] target;
  } result_t;

  class itc_scoreboard;
    logic [31:0] vector, cause, mask, status, epc, count, cmp_a, cmp_b;
    logic [31:0] status_line [STATUS_DELAY_DEPTH];
    result_t     expected_results [$];
    int unsigned failures, checked, irq_entries, timer_ticks, compare_hits;

    function new();
      vector = '0;
      cause = '0;
      mask = '0;
      status = '0;
      epc = '0;
      count = '0;
      cmp_a = '0;
      cmp_b = '0;
      clear_status_line();
      failures = 0;
      checked = 0;
      irq_entries = 0;
      timer_ticks = 0;
      compare_hits = 0;
    endfunction

    function void clear_status_line();
      foreach (status_line[i]) status_line[i] = '0;
    endfunction

    // Advance the controller state by one request and return its result.
    function result_t step_controller(request_t r);
      result_t res;
      logic [31:0] c;
      res = '0;
      case (r.kind)
        REQ_READ: begin
          case (r.idx)
            REG_VECTOR:   res.rdata = vector;
            REG_CAUSE:    res.rdata = cause | CAUSE_READ_SET;
            REG_MASK:     res.rdata = mask;
            REG_STATUS:   res.rdata = status;
            REG_EPC:      res.rdata = epc;
            REG_COUNTER:  res.rdata = count;
            REG_COMPARE:  res.rdata = cmp_a;
            default:      res.rdata = cmp_b;
          endcase
        end
        REQ_WRITE: begin
          case (r.idx)
            REG_VECTOR:  vector = r.wdata;
            REG_CAUSE:   cause = r.wdata;
            REG_MASK:    mask = r.wdata;
            REG_STATUS: begin
              if (r.wdata == '0) begin
                status = '0;
                clear_status_line();
              end else begin
                status_line[STATUS_DELAY_DEPTH-1] = r.wdata;
              end
            end
            REG_EPC:     epc = r.wdata;
            REG_COUNTER: count = r.wdata;
            REG_COMPARE: begin
              cmp_a = r.wdata;
              cause &= CAUSE_KEEP_CMP;
            end
            default: begin
              cmp_b = r.wdata;
              cause &= CAUSE_KEEP_CMP2;
            end
          endcase
        end
        REQ_START: begin
          if (status != '0 && (cause & mask) != '0 && !r.slot) begin
            epc = r.pc + EPC_STEP;
            status = '0;
            clear_status_line();
            res.take = 1'b1;
            res.target = vector;
            irq_entries++;
          end else begin
            // shift towards stage 0, last stage holds its value
            status = status_line[0];
            for (int i = 0; i < STATUS_DELAY_DEPTH - 1; i++) status_line[i] = status_line[i+1];
          end
        end
        default: begin
          count = count + 32'd1;
          timer_ticks++;
          c = cause & CAUSE_KEEP_TICK;
          if (cmp_b[CMP2_BITS-1:0] == count[CMP2_BITS-1:0]) begin
            c[CAUSE_CMP2_BIT] = 1'b1;
            compare_hits++;
          end
          if (cmp_a == count) begin
            c[CAUSE_CMP_BIT] = 1'b1;
            compare_hits++;
          end
          c[3:0] = {~count[CNT_BIT_LO], count[CNT_BIT_LO], ~count[CNT_BIT_HI], count[CNT_BIT_HI]};
          cause = c;
        end
      endcase
      return res;
    endfunction

    function void note_request(request_t r);
      expected_results.push_back(step_controller(r));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result with no request pending: read_data=%h take_irq=%b irq_target=%h",
               got.rdata, got.take, got.target);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (got.rdata !== want.rdata) begin
        $error("read_data: expected %h, got %h", want.rdata, got.rdata);
        failures++;
      end
      if (got.take !== want.take) begin
        $error("take_irq: expected %b, got %b", want.take, got.take);
        failures++;
      end
      if (got.target !== want.target) begin
        $error("irq_target: expected %h, got %h", want.target, got.target);
        failures++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_results.size();
    endfunction
  endclass

endpackage

@@ test/tb.sv @@
// Self-checking testbench of the interrupt and timer controller.
`timescale 1ns / 1ps
module tb;
  import itc_pkg::*;
  import itc_tb_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 900;
  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam int unsigned HOLD_AFTER      = 300;
  localparam int unsigned HOLD_CYCLES     = 200;
  localparam int unsigned MAX_WAIT        = 13;

  logic clk;
  logic rst;

  itc_in_if  in_ch();
  itc_out_if out_ch();

  interrupt_timer_controller_unit uut (
    .clk    (clk),
    .rst    (rst),
    .req_ch (in_ch),
    .rsp_ch (out_ch)
  );

  itc_scoreboard sb = new();

  int unsigned requests_sent = 0;
  int unsigned results_taken = 0;
  bit          in_eager = 1'b0;
  bit          out_eager = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic request_t random_request();
    request_t r;
    r.kind  = req_t'($urandom_range(0, 3));
    r.idx   = reg_idx_t'($urandom_range(0, 7));
    r.wdata = $urandom;
    r.pc    = $urandom;
    r.slot  = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic request_t make_request(req_t kind, reg_idx_t idx, logic [31:0] wdata);
    request_t r;
    r = random_request();
    r.kind  = kind;
    r.idx   = idx;
    r.wdata = wdata;
    return r;
  endfunction

  function automatic request_t start_request(logic [31:0] pc, logic slot);
    request_t r;
    r = random_request();
    r.kind = REQ_START;
    r.pc   = pc;
    r.slot = slot;
    return r;
  endfunction

  task automatic send_request(input request_t r);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) in_eager = !in_eager;
    gap = in_eager ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.req_type      <= r.kind;
    in_ch.reg_index     <= r.idx;
    in_ch.write_data    <= r.wdata;
    in_ch.fetch_pc      <= r.pc;
    in_ch.in_delay_slot <= r.slot;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
  endtask

  task automatic run_directed();
    send_request(make_request(REQ_READ,  REG_CAUSE,    32'h0));
    send_request(make_request(REQ_WRITE, REG_VECTOR,   32'hFFFF_FFFF));
    send_request(make_request(REQ_WRITE, REG_MASK,     32'hFFFF_FFFF));
    send_request(make_request(REQ_WRITE, REG_CAUSE,    32'hFFFF_FFFF));
    send_request(make_request(REQ_READ,  REG_CAUSE,    32'h0));
    send_request(make_request(REQ_WRITE, REG_COMPARE,  32'h0));
    send_request(make_request(REQ_WRITE, REG_COMPARE2, 32'hFFFF_FFFF));
    send_request(make_request(REQ_READ,  REG_CAUSE,    32'h0));
    // status enters at the far end of the delay line and needs four starts to arrive
    send_request(make_request(REQ_WRITE, REG_STATUS,   32'hFFFF_FFFF));
    repeat (4) send_request(start_request(32'h0000_1000, 1'b0));
    send_request(start_request(32'h0000_2000, 1'b1));
    send_request(make_request(REQ_READ,  REG_STATUS,   32'h0));
    // entry at the top of the address space wraps the saved pc to zero
    send_request(start_request(32'hFFFF_FFFC, 1'b0));
    send_request(make_request(REQ_READ,  REG_EPC,      32'h0));
    send_request(make_request(REQ_WRITE, REG_STATUS,   32'h0000_0005));
    send_request(make_request(REQ_WRITE, REG_STATUS,   32'h0));
    send_request(make_request(REQ_WRITE, REG_COUNTER,  32'hFFFF_FFFF));
    send_request(make_request(REQ_TICK,  REG_VECTOR,   32'h0));
    send_request(make_request(REQ_READ,  REG_CAUSE,    32'h0));
    send_request(make_request(REQ_WRITE, REG_COUNTER,  32'h0000_FFFF));
    send_request(make_request(REQ_TICK,  REG_VECTOR,   32'h0));
    send_request(make_request(REQ_READ,  REG_CAUSE,    32'h0));
  endtask

  task automatic irq_sequence();
    int unsigned n;
    send_request(make_request(REQ_WRITE, REG_VECTOR, $urandom));
    send_request(make_request(REQ_WRITE, REG_MASK,
                              ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom));
    send_request(make_request(REQ_WRITE, REG_CAUSE,
                              ($urandom_range(0, 1) == 0) ? $urandom : 32'd1 << $urandom_range(0, 31)));
    if ($urandom_range(0, 2) == 0) send_request(make_request(REQ_TICK, REG_CAUSE, $urandom));
    n = $urandom_range(1, 2);
    repeat (n) begin
      send_request(make_request(REQ_WRITE, REG_STATUS,
                                ($urandom_range(0, 5) == 0) ? 32'h0 : $urandom));
    end
    n = $urandom_range(1, 7);
    repeat (n) begin
      send_request(start_request($urandom, $urandom_range(0, 3) == 0));
      if ($urandom_range(0, 3) == 0) begin
        send_request(make_request(REQ_READ, reg_idx_t'($urandom_range(0, 7)), $urandom));
      end
    end
    send_request(make_request(REQ_READ, REG_EPC, $urandom));
  endtask

  task automatic timer_sequence();
    logic [31:0] base, hit, cmp2;
    int unsigned n;
    base = $urandom;
    // park the counter just short of a carry into bit 16 or bit 18, or of wraparound
    case ($urandom_range(0, 3))
      0: base[15:0] = 16'hFFFC;
      1: base[17:0] = 18'h3FFFC;
      2: base = 32'hFFFF_FFFC;
      default: ;
    endcase
    send_request(make_request(REQ_WRITE, REG_COUNTER, base));
    send_request(make_request(REQ_WRITE, REG_COMPARE, base + $urandom_range(1, 6)));
    hit = base + $urandom_range(1, 6);
    cmp2 = $urandom;
    cmp2[23:0] = hit[23:0];
    send_request(make_request(REQ_WRITE, REG_COMPARE2, cmp2));
    n = $urandom_range(1, 8);
    repeat (n) begin
      send_request(make_request(REQ_TICK, reg_idx_t'($urandom_range(0, 7)), $urandom));
      if ($urandom_range(0, 2) == 0) send_request(make_request(REQ_READ, REG_CAUSE, $urandom));
    end
    if ($urandom_range(0, 3) == 0) send_request(make_request(REQ_WRITE, REG_COMPARE, $urandom));
    send_request(make_request(REQ_READ, REG_CAUSE, $urandom));
    send_request(make_request(REQ_READ, REG_COUNTER, $urandom));
  endtask

  task automatic run_random();
    int unsigned first, n;
    first = requests_sent;
    while (requests_sent - first < RANDOM_REQUESTS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: irq_sequence();
        4, 5, 6:    timer_sequence();
        default: begin
          n = $urandom_range(1, 10);
          repeat (n) send_request(random_request());
        end
      endcase
    end
  endtask

  // result side: random stalls, one long hold-off to back the block up
  initial begin
    int unsigned stall;
    bit          held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_eager = !out_eager;
      if (!held && results_taken == HOLD_AFTER) begin
        held = 1'b1;
        stall = HOLD_CYCLES;
      end else begin
        stall = out_eager ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      results_taken++;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      sb.note_request(request_t'{req_t'(in_ch.req_type), reg_idx_t'(in_ch.reg_index),
                                 in_ch.write_data, in_ch.fetch_pc, in_ch.in_delay_slot});
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_result(result_t'{out_ch.read_data, out_ch.take_irq, out_ch.irq_target});
    end
  end

  // end the run if neither side moves for too long
  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $error("no handshake for %0d cycles, %0d results outstanding", IDLE_LIMIT, sb.outstanding());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.req_type      <= REQ_READ;
    in_ch.reg_index     <= REG_VECTOR;
    in_ch.write_data    <= '0;
    in_ch.fetch_pc      <= '0;
    in_ch.in_delay_slot <= 1'b0;
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("%0d requests sent, %0d results checked, %0d failures",
             requests_sent, sb.checked, sb.failures);
    $display("%0d interrupt entries, %0d timer ticks, %0d compare matches",
             sb.irq_entries, sb.timer_ticks, sb.compare_hits);
    if (sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
